// ===== hw/rtl/cvad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cvad_pkg;

   localparam int INDEX_W = 8;
   localparam int PRICE_W = 32;
   localparam int SIZE_W  = 24;
   localparam int CFG_W   = 24;
   localparam int PDATA_W = 32;
   localparam int PADDR_W = 3;

   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [PRICE_W-1:0] price_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [CFG_W-1:0]   cfg_type;

   typedef struct packed {
      price_type price;
      size_type  size;
   } side_type;

   // register codes, taken from paddr[2]
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_AGGR      = 1'b1;

   localparam logic VENUE_A = 1'b0;
   localparam logic VENUE_B = 1'b1;

   localparam cfg_type THRESHOLD_RESET = 24'd100;
   localparam cfg_type AGGR_RESET      = 24'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/cvad_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cvad_req_if;
   logic                 valid;
   logic                 ready;
   cvad_pkg::index_type  instrument_index;
   logic                 venue;
   logic                 bid_present;
   cvad_pkg::price_type  bid_price;
   cvad_pkg::size_type   bid_qty;
   logic                 ask_present;
   cvad_pkg::price_type  ask_price;
   cvad_pkg::size_type   ask_qty;

   modport source (
      output valid, instrument_index, venue, bid_present, bid_price, bid_qty,
             ask_present, ask_price, ask_qty,
      input  ready
   );

   modport sink (
      input  valid, instrument_index, venue, bid_present, bid_price, bid_qty,
             ask_present, ask_price, ask_qty,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/cvad_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cvad_rsp_if;
   logic                 valid;
   logic                 ready;
   cvad_pkg::index_type  order_instrument;
   logic                 order_venue;
   logic                 order_is_buy;
   cvad_pkg::size_type   order_quantity;
   cvad_pkg::price_type  order_price;
   logic                 last_order;

   modport source (
      output valid, order_instrument, order_venue, order_is_buy, order_quantity,
             order_price, last_order,
      input  ready
   );

   modport sink (
      input  valid, order_instrument, order_venue, order_is_buy, order_quantity,
             order_price, last_order,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/cvad_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cvad_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cross_venue_arb_detector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Cross-venue arbitrage detector.
// req_ch carries quote updates for one instrument slot on venue A or B; rsp_ch
// returns limit orders, always as a pair: the buy leg first, then the sell leg
// with last_order set. Updates whose slot lies beyond INSTRUMENT_SLOTS are
// taken and dropped. The APB port writes and reads the edge threshold (0x0) and
// aggressiveness (0x4); write them only while no request is in flight.
// The buy leg passes the stage 1, stage 2 and order pair buffer registers
// before rsp_ch offers it; once the buy leg is taken, the buffer registers
// the switch to the sell leg. One request per cycle is taken when no cross is
// found; a request that produces a pair holds the single result port for both
// legs; the order pair buffer loads a new pair once its sell leg is taken.
// Quote sides live in four block RAMs (bid and ask per venue), each entry with
// its own seen bit, written and read at the cycle a request is taken.
// After reset a clearing pass zeroes one row per cycle through all ROWS rows
// (256 at the default table size); req_ch.ready stays low until it ends.
// When rsp_ch stalls, the pipeline fills and req_ch.ready drops; nothing is
// lost or repeated.
module cross_venue_arb_detector_core #(
   parameter int INSTRUMENT_SLOTS = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   cvad_req_if.sink                      req_ch,
   cvad_rsp_if.source                    rsp_ch,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [cvad_pkg::PADDR_W-1:0] paddr,
   input  wire logic [cvad_pkg::PDATA_W-1:0] pwdata,
   output logic      [cvad_pkg::PDATA_W-1:0] prdata,
   output logic                          pready
);

   localparam int ROWS   = (INSTRUMENT_SLOTS < 256) ? INSTRUMENT_SLOTS : 256;
   localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SIDE_W = $bits(cvad_pkg::side_type);

   // configuration
   cvad_pkg::cfg_type thr_ff, aggr_ff;
   logic              cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= cvad_pkg::THRESHOLD_RESET;
         aggr_ff <= cvad_pkg::AGGR_RESET;
      end else if (cfg_wr) begin
         case (paddr[2])
            cvad_pkg::REG_THRESHOLD: thr_ff  <= pwdata[cvad_pkg::CFG_W-1:0];
            cvad_pkg::REG_AGGR:      aggr_ff <= pwdata[cvad_pkg::CFG_W-1:0];
            default:                 thr_ff  <= thr_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         cvad_pkg::REG_THRESHOLD: prdata = cvad_pkg::PDATA_W'(thr_ff);
         cvad_pkg::REG_AGGR:      prdata = cvad_pkg::PDATA_W'(aggr_ff);
         default:                 prdata = '0;
      endcase
   end

   // clearing pass after reset: zero one row of every RAM per cycle
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(ROWS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, s2_hit_ff;
   logic out_valid_ff, out_leg_ff;
   logic out_free, s2_free, req_fire, rsp_fire;

   assign rsp_fire      = out_valid_ff && rsp_ch.ready;
   assign out_free      = !out_valid_ff || (out_leg_ff && rsp_ch.ready);
   assign s2_free       = !s2_valid_ff || !s2_hit_ff || out_free;
   assign req_ch.ready  = !clr_busy_ff && (!s1_valid_ff || s2_free);
   assign req_fire      = req_ch.valid && req_ch.ready;

   // accept stage: write present sides, read all four sides of the slot
   logic          in_range;
   logic [AW-1:0] addr;
   logic          wr_a_bid, wr_a_ask, wr_b_bid, wr_b_ask;

   assign in_range = 32'(req_ch.instrument_index) < 32'(INSTRUMENT_SLOTS);
   assign addr     = req_ch.instrument_index[AW-1:0];

   assign wr_a_bid = req_fire && in_range && (req_ch.venue == cvad_pkg::VENUE_A)
                     && req_ch.bid_present;
   assign wr_a_ask = req_fire && in_range && (req_ch.venue == cvad_pkg::VENUE_A)
                     && req_ch.ask_present;
   assign wr_b_bid = req_fire && in_range && (req_ch.venue == cvad_pkg::VENUE_B)
                     && req_ch.bid_present;
   assign wr_b_ask = req_fire && in_range && (req_ch.venue == cvad_pkg::VENUE_B)
                     && req_ch.ask_present;

   cvad_pkg::side_type new_bid, new_ask;
   logic [SIDE_W:0]    q_a_bid, q_a_ask, q_b_bid, q_b_ask;
   logic [SIDE_W:0]    bid_wdata, ask_wdata;
   logic [AW-1:0]      ram_waddr;

   assign new_bid = '{price: req_ch.bid_price, size: req_ch.bid_qty};
   assign new_ask = '{price: req_ch.ask_price, size: req_ch.ask_qty};

   // top bit of every entry marks the side as seen
   assign ram_waddr = clr_busy_ff ? clr_addr_ff : addr;
   assign bid_wdata = clr_busy_ff ? '0 : {1'b1, new_bid};
   assign ask_wdata = clr_busy_ff ? '0 : {1'b1, new_ask};

   cvad_ram #(.WIDTH(SIDE_W + 1), .DEPTH(ROWS)) u_a_bid (
      .clock(clock), .we(clr_busy_ff || wr_a_bid), .waddr(ram_waddr), .wdata(bid_wdata),
      .re(req_fire), .raddr(addr), .rdata(q_a_bid)
   );
   cvad_ram #(.WIDTH(SIDE_W + 1), .DEPTH(ROWS)) u_a_ask (
      .clock(clock), .we(clr_busy_ff || wr_a_ask), .waddr(ram_waddr), .wdata(ask_wdata),
      .re(req_fire), .raddr(addr), .rdata(q_a_ask)
   );
   cvad_ram #(.WIDTH(SIDE_W + 1), .DEPTH(ROWS)) u_b_bid (
      .clock(clock), .we(clr_busy_ff || wr_b_bid), .waddr(ram_waddr), .wdata(bid_wdata),
      .re(req_fire), .raddr(addr), .rdata(q_b_bid)
   );
   cvad_ram #(.WIDTH(SIDE_W + 1), .DEPTH(ROWS)) u_b_ask (
      .clock(clock), .we(clr_busy_ff || wr_b_ask), .waddr(ram_waddr), .wdata(ask_wdata),
      .re(req_fire), .raddr(addr), .rdata(q_b_ask)
   );

   // stage 1 registers
   cvad_pkg::index_type s1_instrument_ff;
   logic                s1_venue_ff, s1_bid_present_ff, s1_ask_present_ff;
   cvad_pkg::side_type  s1_bid_ff, s1_ask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_fire && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_instrument_ff  <= req_ch.instrument_index;
         s1_venue_ff       <= req_ch.venue;
         s1_bid_present_ff <= req_ch.bid_present;
         s1_ask_present_ff <= req_ch.ask_present;
         s1_bid_ff         <= new_bid;
         s1_ask_ff         <= new_ask;
      end
   end

   // stage 1 logic: take this request's sides over the RAM copies, find cross
   cvad_pkg::side_type a_bid, a_ask, b_bid, b_ask, buy_ask, sell_bid;
   logic                      use_a_bid, use_a_ask, use_b_bid, use_b_ask, all_seen;
   logic                      b_over_a, a_over_b, s1_hit;
   logic [cvad_pkg::PRICE_W:0] a_ask_edge, b_ask_edge;
   cvad_pkg::size_type        s1_qty;

   assign use_a_bid = (s1_venue_ff == cvad_pkg::VENUE_A) && s1_bid_present_ff;
   assign use_a_ask = (s1_venue_ff == cvad_pkg::VENUE_A) && s1_ask_present_ff;
   assign use_b_bid = (s1_venue_ff == cvad_pkg::VENUE_B) && s1_bid_present_ff;
   assign use_b_ask = (s1_venue_ff == cvad_pkg::VENUE_B) && s1_ask_present_ff;

   always_comb begin
      a_bid = use_a_bid ? s1_bid_ff : cvad_pkg::side_type'(q_a_bid[SIDE_W-1:0]);
      a_ask = use_a_ask ? s1_ask_ff : cvad_pkg::side_type'(q_a_ask[SIDE_W-1:0]);
      b_bid = use_b_bid ? s1_bid_ff : cvad_pkg::side_type'(q_b_bid[SIDE_W-1:0]);
      b_ask = use_b_ask ? s1_ask_ff : cvad_pkg::side_type'(q_b_ask[SIDE_W-1:0]);

      all_seen = (use_a_bid || q_a_bid[SIDE_W]) && (use_a_ask || q_a_ask[SIDE_W])
                 && (use_b_bid || q_b_bid[SIDE_W]) && (use_b_ask || q_b_ask[SIDE_W]);

      a_ask_edge = {1'b0, a_ask.price} + (cvad_pkg::PRICE_W + 1)'(thr_ff);
      b_ask_edge = {1'b0, b_ask.price} + (cvad_pkg::PRICE_W + 1)'(thr_ff);
      b_over_a   = {1'b0, b_bid.price} >= a_ask_edge;
      a_over_b   = {1'b0, a_bid.price} >= b_ask_edge;

      // buy on A when B's bid crosses A's ask, else the reverse
      buy_ask  = b_over_a ? a_ask : b_ask;
      sell_bid = b_over_a ? b_bid : a_bid;
      s1_qty   = (buy_ask.size < sell_bid.size) ? buy_ask.size : sell_bid.size;
      s1_hit   = all_seen && (b_over_a || a_over_b) && (s1_qty != '0);
   end

   // stage 2 registers
   cvad_pkg::index_type s2_instrument_ff;
   logic                s2_buy_venue_ff;
   cvad_pkg::size_type  s2_qty_ff;
   cvad_pkg::price_type s2_ask_ff, s2_bid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_hit_ff   <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
         s2_hit_ff   <= s1_valid_ff && s1_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_instrument_ff <= s1_instrument_ff;
         s2_buy_venue_ff  <= b_over_a ? cvad_pkg::VENUE_A : cvad_pkg::VENUE_B;
         s2_qty_ff        <= s1_qty;
         s2_ask_ff        <= buy_ask.price;
         s2_bid_ff        <= sell_bid.price;
      end
   end

   // stage 2 logic: limit prices, clamp at zero and saturate at full scale
   cvad_pkg::price_type        buy_price, sell_price;
   logic [cvad_pkg::PRICE_W:0] sell_sum;

   always_comb begin
      buy_price = (s2_ask_ff >= cvad_pkg::PRICE_W'(aggr_ff))
                  ? s2_ask_ff - cvad_pkg::PRICE_W'(aggr_ff) : '0;
      sell_sum  = {1'b0, s2_bid_ff} + (cvad_pkg::PRICE_W + 1)'(aggr_ff);
      sell_price = sell_sum[cvad_pkg::PRICE_W] ? '1 : sell_sum[cvad_pkg::PRICE_W-1:0];
   end

   // order pair buffer
   cvad_pkg::index_type out_instrument_ff;
   logic                out_buy_venue_ff;
   cvad_pkg::size_type  out_qty_ff;
   cvad_pkg::price_type out_buy_price_ff, out_sell_price_ff;
   logic                out_valid_in, out_leg_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_leg_in   = out_leg_ff;
      if (out_free) begin
         out_valid_in = s2_valid_ff && s2_hit_ff;
         out_leg_in   = 1'b0;
      end else if (rsp_fire) begin
         out_leg_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_leg_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         out_leg_ff   <= out_leg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_instrument_ff <= s2_instrument_ff;
         out_buy_venue_ff  <= s2_buy_venue_ff;
         out_qty_ff        <= s2_qty_ff;
         out_buy_price_ff  <= buy_price;
         out_sell_price_ff <= sell_price;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.order_instrument = out_instrument_ff;
   assign rsp_ch.order_venue      = out_leg_ff ? !out_buy_venue_ff : out_buy_venue_ff;
   assign rsp_ch.order_is_buy     = !out_leg_ff;
   assign rsp_ch.order_quantity   = out_qty_ff;
   assign rsp_ch.order_price      = out_leg_ff ? out_sell_price_ff : out_buy_price_ff;
   assign rsp_ch.last_order       = out_leg_ff;

   // the sell leg always follows a taken buy leg
   a_sell_follows_buy : assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !out_leg_ff |=> out_valid_ff && out_leg_ff)
      else $error("sell leg missing after buy leg");

   a_qty_nonzero : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_qty_ff != '0)
      else $error("order with zero quantity");

   // a request is refused only while clearing or when both stages are occupied
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> clr_busy_ff || (s1_valid_ff && s2_valid_ff && s2_hit_ff))
      else $error("request refused with room in pipeline");

   a_s2_hold : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_hit_ff && !out_free |=> s2_valid_ff && s2_hit_ff
         && $stable(s2_qty_ff) && $stable(s2_instrument_ff))
      else $error("pending order pair lost under stall");

endmodule

`default_nettype wire

// ===== bench/arb_order_checker.sv =====
`timescale 1ns / 1ps

module arb_order_checker
   import cvad_pkg::*;
#(
   parameter int TABLE_SLOTS = 256
) (
   input  wire logic               clock,
   input  wire logic               reset,
   cvad_req_if                     req,
   cvad_rsp_if                     rsp,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic               pready,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   input  wire logic [PDATA_W-1:0] prdata,
   output int                      failures,
   output int                      orders_checked,
   output int                      orders_pending
);

   localparam int ENTRIES = 2 * TABLE_SLOTS;

   typedef logic [PRICE_W:0] wide_price_type;

   typedef struct packed {
      index_type instrument;
      logic      venue;
      logic      is_buy;
      size_type  quantity;
      price_type price;
      logic      last;
   } limit_order_type;

   limit_order_type expected_orders[$];

   // one entry per slot and venue: slot * 2 + venue
   price_type bid_price_tab[ENTRIES];
   size_type  bid_qty_tab[ENTRIES];
   price_type ask_price_tab[ENTRIES];
   size_type  ask_qty_tab[ENTRIES];
   logic      bid_seen_tab[ENTRIES];
   logic      ask_seen_tab[ENTRIES];

   cfg_type threshold_reg;
   cfg_type aggr_reg;

   task automatic flag_fault(input string msg);
      failures++;
      $display("%0t checker: %s", $time, msg);
   endtask

   function automatic string describe(input limit_order_type o);
      return $sformatf("slot %0d venue %0d %s qty %0d price %0d last %0d",
                       o.instrument, o.venue, o.is_buy ? "buy" : "sell",
                       o.quantity, o.price, o.last);
   endfunction

   // Store the quote sides, then look for a cross between the two venues.
   task automatic take_quote();
      int unsigned     own, ea, eb, buy_e, sell_e;
      size_type        qty;
      price_type       buy_px;
      wide_price_type  sell_px;
      limit_order_type o;

      if (int'(req.instrument_index) >= TABLE_SLOTS) return;
      own = 2 * req.instrument_index + req.venue;
      if (req.bid_present) begin
         bid_price_tab[own] = req.bid_price;
         bid_qty_tab[own]   = req.bid_qty;
         bid_seen_tab[own]  = 1'b1;
      end
      if (req.ask_present) begin
         ask_price_tab[own] = req.ask_price;
         ask_qty_tab[own]   = req.ask_qty;
         ask_seen_tab[own]  = 1'b1;
      end

      ea = 2 * req.instrument_index;
      eb = ea + 1;
      if (!(bid_seen_tab[ea] && ask_seen_tab[ea] && bid_seen_tab[eb] && ask_seen_tab[eb]))
         return;

      // sums are taken one bit wider so they never wrap
      if (wide_price_type'(bid_price_tab[eb]) >=
          wide_price_type'(ask_price_tab[ea]) + wide_price_type'(threshold_reg)) begin
         buy_e  = ea;
         sell_e = eb;
      end else if (wide_price_type'(bid_price_tab[ea]) >=
                   wide_price_type'(ask_price_tab[eb]) + wide_price_type'(threshold_reg)) begin
         buy_e  = eb;
         sell_e = ea;
      end else begin
         return;
      end

      qty = (ask_qty_tab[buy_e] < bid_qty_tab[sell_e]) ? ask_qty_tab[buy_e]
                                                       : bid_qty_tab[sell_e];
      if (qty == '0) return;

      buy_px  = (ask_price_tab[buy_e] >= aggr_reg) ? ask_price_tab[buy_e] - aggr_reg : '0;
      sell_px = wide_price_type'(bid_price_tab[sell_e]) + wide_price_type'(aggr_reg);
      if (sell_px[PRICE_W]) sell_px = {1'b0, {PRICE_W{1'b1}}};

      o.instrument = req.instrument_index;
      o.venue      = buy_e[0];
      o.is_buy     = 1'b1;
      o.quantity   = qty;
      o.price      = buy_px;
      o.last       = 1'b0;
      expected_orders.push_back(o);
      o.venue      = sell_e[0];
      o.is_buy     = 1'b0;
      o.price      = sell_px[PRICE_W-1:0];
      o.last       = 1'b1;
      expected_orders.push_back(o);
   endtask

   task automatic match_order();
      limit_order_type got, want;
      string           diffs;

      got.instrument = rsp.order_instrument;
      got.venue      = rsp.order_venue;
      got.is_buy     = rsp.order_is_buy;
      got.quantity   = rsp.order_quantity;
      got.price      = rsp.order_price;
      got.last       = rsp.last_order;
      orders_checked++;
      if (expected_orders.size() == 0) begin
         flag_fault($sformatf("order with none pending: %s", describe(got)));
         return;
      end
      want  = expected_orders.pop_front();
      diffs = "";
      if (got.instrument !== want.instrument) diffs = {diffs, " instrument"};
      if (got.venue !== want.venue)           diffs = {diffs, " venue"};
      if (got.is_buy !== want.is_buy)         diffs = {diffs, " side"};
      if (got.quantity !== want.quantity)     diffs = {diffs, " quantity"};
      if (got.price !== want.price)           diffs = {diffs, " price"};
      if (got.last !== want.last)             diffs = {diffs, " last"};
      if (diffs != "")
         flag_fault($sformatf("wrong%s: got %s, expected %s", diffs, describe(got),
                              describe(want)));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_orders.delete();
         foreach (bid_seen_tab[i]) begin
            bid_seen_tab[i] = 1'b0;
            ask_seen_tab[i] = 1'b0;
         end
         threshold_reg = THRESHOLD_RESET;
         aggr_reg      = AGGR_RESET;
      end else begin
         if (rsp.valid && rsp.ready) match_order();
         if (req.valid && req.ready) take_quote();
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[2])
                  REG_THRESHOLD: threshold_reg = pwdata[CFG_W-1:0];
                  REG_AGGR:      aggr_reg      = pwdata[CFG_W-1:0];
               endcase
            end else if (prdata[CFG_W-1:0] !==
                         ((paddr[2] == REG_AGGR) ? aggr_reg : threshold_reg)) begin
               flag_fault($sformatf("register read at 0x%0h returned 0x%0h", paddr, prdata));
            end
         end
      end
      orders_pending = expected_orders.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cvad_pkg::*;

   localparam int SLOTS        = 256;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 290;
   localparam int HOT          = 8;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      index_type slot;
      logic      venue;
      logic      has_bid;
      price_type bid_price;
      size_type  bid_qty;
      logic      has_ask;
      price_type ask_price;
      size_type  ask_qty;
   } quote_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic               pready;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;

   int          failures;
   int          orders_checked;
   int          orders_pending;
   int          updates_sent;
   int          settings_applied;
   bit          source_steady;
   bit          sink_steady;
   cfg_type     cur_threshold;
   index_type   hot_slots[HOT];
   logic [63:0] hot_base[HOT];

   cvad_req_if req_ch();
   cvad_rsp_if rsp_ch();

   cross_venue_arb_detector_core #(
      .INSTRUMENT_SLOTS(SLOTS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   arb_order_checker #(
      .TABLE_SLOTS(SLOTS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .failures       (failures),
      .orders_checked (orders_checked),
      .orders_pending (orders_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   // order sink: stall in bursts unless told to stay steady
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!sink_steady && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   end

   function automatic size_type random_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return size_type'($urandom);
         default: return size_type'($urandom_range(1, 500));
      endcase
   endfunction

   // Base price for a slot, leaving room above it for the threshold.
   function automatic logic [63:0] fresh_base();
      logic [63:0] ceiling;
      ceiling = 64'hFFFF_FFFF - cur_threshold - 16;
      case ($urandom_range(0, 5))
         0:       return 64'd8;
         1:       return ceiling + 12;
         default: return {32'b0, $urandom_range(8, ceiling[31:0])};
      endcase
   endfunction

   // Mostly quotes on a few busy slots priced around the threshold, so that
   // crosses come and go; the rest is unrelated noise over the whole table.
   function automatic quote_type random_quote();
      quote_type   q;
      logic [63:0] px;
      int unsigned h, shape;
      if ($urandom_range(0, 3) == 0) begin
         q.slot      = index_type'($urandom);
         q.venue     = 1'($urandom);
         q.has_bid   = 1'($urandom);
         q.bid_price = $urandom;
         q.bid_qty   = size_type'($urandom);
         q.has_ask   = 1'($urandom);
         q.ask_price = $urandom;
         q.ask_qty   = size_type'($urandom);
         return q;
      end
      h = $urandom_range(0, HOT - 1);
      if ($urandom_range(0, 19) == 0) hot_base[h] = fresh_base();
      shape       = $urandom_range(0, 9);
      q.slot      = hot_slots[h];
      q.venue     = 1'($urandom_range(0, 1));
      q.has_bid   = (shape < 8);
      q.has_ask   = (shape < 6) || (shape == 8);
      px          = hot_base[h] + cur_threshold + $urandom_range(0, 16) - 4;
      q.bid_price = (px > 64'hFFFF_FFFF) ? '1 : px[31:0];
      px          = hot_base[h] + $urandom_range(0, 8);
      q.ask_price = (px > 64'hFFFF_FFFF) ? '1 : px[31:0];
      q.bid_qty   = random_size();
      q.ask_qty   = random_size();
      return q;
   endfunction

   task automatic send_quote(input quote_type q);
      @(negedge clock);
      req_ch.valid            <= 1'b1;
      req_ch.instrument_index <= q.slot;
      req_ch.venue            <= q.venue;
      req_ch.bid_present      <= q.has_bid;
      req_ch.bid_price        <= q.bid_price;
      req_ch.bid_qty          <= q.bid_qty;
      req_ch.ask_present      <= q.has_ask;
      req_ch.ask_price        <= q.ask_price;
      req_ch.ask_qty          <= q.ask_qty;
      do @(posedge clock); while (!req_ch.ready);
      updates_sent++;
   endtask

   task automatic hold_source(input int unsigned cycles);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Drop valid, wait until every order has come back, then let the pipeline drain.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (orders_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic sel, input cfg_type value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {sel, 2'b00};
      // junk in the upper bits must be masked off
      pwdata  <= {8'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_setting(input cfg_type thr, input cfg_type aggr);
      csr_access(1'b1, REG_THRESHOLD, thr);
      csr_access(1'b1, REG_AGGR, aggr);
      csr_access(1'b0, REG_THRESHOLD, '0);
      csr_access(1'b0, REG_AGGR, '0);
      cur_threshold = thr;
      settings_applied++;
   endtask

   initial begin
      int unsigned p, k;
      cfg_type     thr, aggr;

      req_ch.valid            = 1'b0;
      req_ch.instrument_index = '0;
      req_ch.venue            = VENUE_A;
      req_ch.bid_present      = 1'b0;
      req_ch.bid_price        = '0;
      req_ch.bid_qty          = '0;
      req_ch.ask_present      = 1'b0;
      req_ch.ask_price        = '0;
      req_ch.ask_qty          = '0;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b0;
      paddr                   = '0;
      pwdata                  = '0;
      reset                   = 1'b1;
      source_steady           = 1'b0;
      sink_steady             = 1'b0;
      cur_threshold           = THRESHOLD_RESET;
      updates_sent            = 0;
      settings_applied        = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers must read back their reset values
      csr_access(1'b0, REG_THRESHOLD, '0);
      csr_access(1'b0, REG_AGGR, '0);

      // reset setting: threshold 100, no price offset
      send_quote('{8'd3, VENUE_A, 1'b1, 32'd1000, 24'd10, 1'b1, 32'd1010, 24'd20});
      send_quote('{8'd3, VENUE_B, 1'b1, 32'd1110, 24'd5, 1'b0, 32'd0, 24'd0});
      // last side seen: buy on A, sell on B at exactly the threshold
      send_quote('{8'd3, VENUE_B, 1'b0, 32'd0, 24'd0, 1'b1, 32'd1200, 24'd7});
      // no side present: stores untouched, cross fires again
      send_quote('{8'd3, VENUE_B, 1'b0, 32'hDEAD_BEEF, 24'hABCDEF, 1'b0, 32'h1234_5678,
                   24'h654321});
      send_quote('{8'd3, VENUE_A, 1'b0, 32'd0, 24'd0, 1'b1, 32'd1011, 24'd20});
      // cross the other way but with zero size on the sell side
      send_quote('{8'd3, VENUE_A, 1'b1, 32'd1300, 24'd0, 1'b0, 32'd0, 24'd0});
      send_quote('{8'd3, VENUE_A, 1'b1, 32'd1300, 24'd9, 1'b0, 32'd0, 24'd0});
      send_quote('{8'd255, VENUE_A, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 32'd0,
                   24'hFF_FFFF});
      send_quote('{8'd255, VENUE_B, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 32'd0,
                   24'hFF_FFFF});
      send_quote('{8'd0, VENUE_B, 1'b1, 32'd0, 24'd1, 1'b1, 32'hFFFF_FFFF, 24'd1});
      // threshold sum above the price range: no cross
      send_quote('{8'd0, VENUE_A, 1'b1, 32'd0, 24'd2, 1'b1, 32'hFFFF_FFFF, 24'd2});
      settle();

      // zero threshold, largest offset: buy clamps at zero, sell saturates
      apply_setting('0, '1);
      send_quote('{8'd0, VENUE_A, 1'b0, 32'd0, 24'd0, 1'b1, 32'd0, 24'd3});
      send_quote('{8'd255, VENUE_A, 1'b1, 32'hFFFF_FFFF, 24'd4, 1'b0, 32'd0, 24'd0});
      send_quote('{8'd7, VENUE_A, 1'b1, 32'd500, 24'd11, 1'b1, 32'd500, 24'd12});
      send_quote('{8'd7, VENUE_B, 1'b1, 32'd500, 24'd13, 1'b1, 32'd500, 24'd14});
      settle();

      // largest threshold
      apply_setting('1, 24'd1);
      send_quote('{8'd9, VENUE_A, 1'b1, 32'd1, 24'd5, 1'b1, 32'hFFFF_0000, 24'd5});
      send_quote('{8'd9, VENUE_B, 1'b1, 32'hFFFF_FFFF, 24'd5, 1'b1, 32'hFFFF_FFFF, 24'd5});
      send_quote('{8'd10, VENUE_A, 1'b1, 32'd0, 24'd6, 1'b1, 32'd5, 24'd6});
      send_quote('{8'd10, VENUE_B, 1'b1, 32'h0100_0004, 24'd8, 1'b1, 32'hFFFF_FFFF, 24'd8});
      send_quote('{8'd10, VENUE_B, 1'b1, 32'h0100_0003, 24'd8, 1'b0, 32'd0, 24'd0});
      settle();

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               thr  = '0;
               aggr = '0;
            end
            1: begin
               thr  = 24'd1;
               aggr = 24'd25;
            end
            2: begin
               thr  = cfg_type'($urandom_range(0, 2000));
               aggr = cfg_type'($urandom_range(0, 1000));
            end
            3: begin
               thr  = '1;
               aggr = '1;
            end
            4: begin
               thr  = THRESHOLD_RESET;
               aggr = AGGR_RESET;
            end
            default: begin
               thr  = cfg_type'($urandom);
               aggr = cfg_type'($urandom);
            end
         endcase
         apply_setting(thr, aggr);
         foreach (hot_slots[i]) begin
            hot_slots[i] = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : index_type'($urandom);
            hot_base[i]  = fresh_base();
         end
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // the final phase and every third stretch run without gaps
            source_steady = (p == PHASES - 1) || ((k / 50) % 3 == 2);
            sink_steady   = source_steady;
            send_quote(random_quote());
            if (!source_steady && $urandom_range(0, 3) == 0) hold_source($urandom_range(1, 11));
         end
         settle();
      end

      $display("summary: %0d quote updates under %0d register settings, %0d orders checked",
               updates_sent, settings_applied, orders_checked);
      if (failures == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
